/* rtl/core/oaht_pkg.sv */
// Shared types, codes and sizing constants of the open-addressing hash table.
// No dependencies; every other file of the block refers to it by scoped names.
package oaht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W       = 31;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 6;
    localparam int TAG_W       = 2;
    localparam int CFG_SIZE_W  = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // Remainder unit: a few restoring steps per cycle over a zero-padded key.
    localparam int DIV_BITS    = 4;
    localparam int DIV_W       = DIV_BITS * ((KEY_W + DIV_BITS - 1) / DIV_BITS);
    localparam int DIV_CYC     = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_GONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'd1;

    // One access to the slot store: a read, a write, or neither.
    typedef struct packed {
        logic              re;
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [TAG_W-1:0]  tag;
        logic [KEY_W-1:0]  key;
    } st_req_t;

endpackage

/* rtl/core/oaht_mod.sv */
// Iterative remainder unit: key modulo the live table size, DIV_BITS bits a cycle.
// Depends on oaht_pkg.
module oaht_mod
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [oaht_pkg::KEY_W-1:0]  key,
    input  logic [oaht_pkg::SIZE_W-1:0] size,
    output logic                        busy,
    output logic                        done,
    output logic [oaht_pkg::SIZE_W-1:0] rem
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [oaht_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [oaht_pkg::DIV_W-1:0]     q_reg, q_next;
    logic [oaht_pkg::SIZE_W-1:0]    r_reg, r_next;
    logic [oaht_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic [oaht_pkg::SIZE_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        size_next = size_reg;
        trial     = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = oaht_pkg::DIV_W'(key);
            r_next    = '0;
            size_next = size;
        end
        else if (busy_reg)
        begin
            // Restoring steps: the partial remainder always stays below the size.
            for (int b = 0; b < oaht_pkg::DIV_BITS; b++)
            begin
                trial = {r_next, q_next[oaht_pkg::DIV_W-1]};
                if (trial >= {1'b0, size_reg})
                begin
                    trial = trial - {1'b0, size_reg};
                end
                r_next = trial[oaht_pkg::SIZE_W-1:0];
                q_next = {q_next[oaht_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == oaht_pkg::DIV_CNT_W'(oaht_pkg::DIV_CYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        size_reg <= size_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = r_reg;

endmodule

/* rtl/core/oaht_store.sv */
// Slot store: tag and key memory with one registered read port and one write port.
// Per-slot valid bits make unwritten slots read as empty. Depends on oaht_pkg.
module oaht_store
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  oaht_pkg::st_req_t          req,
    output logic [oaht_pkg::TAG_W-1:0] rd_tag,
    output logic [oaht_pkg::KEY_W-1:0] rd_key
);

    logic [oaht_pkg::TAG_W+oaht_pkg::KEY_W-1:0] mem [oaht_pkg::TABLE_DEPTH];
    logic [oaht_pkg::TABLE_DEPTH-1:0]           valid_reg;
    logic                                       rd_valid_reg;
    logic [oaht_pkg::TAG_W+oaht_pkg::KEY_W-1:0] rd_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= {req.tag, req.key};
        end
        if (req.re)
        begin
            rd_word_reg <= mem[req.addr];
        end
    end

    assign rd_tag = rd_valid_reg ? rd_word_reg[oaht_pkg::TAG_W+oaht_pkg::KEY_W-1:oaht_pkg::KEY_W]
                                 : oaht_pkg::TAG_EMPTY;
    assign rd_key = rd_word_reg[oaht_pkg::KEY_W-1:0];

endmodule

/* rtl/core/open_addressing_hash_table.sv */
// Open-addressing hash table of 31-bit keys with insert, search and delete. An
// operation is taken when start is high and busy is low, and its one result beat
// appears on status and slot for a single cycle with done high; the receiver
// cannot stall it, so it must take every beat. An operation first finds its home
// slot with the remainder unit and then probes n slots in turn, where n is 1 to
// the live table size; each probe reads the slot memory and then checks the slot.
// Busy drops together with done, so the next operation can be taken at the edge
// that ends the result beat. An undefined function code answers key absent in
// the next cycle. Slots are empty right after reset with no clearing pass.
// Configuration writes are always ready and must be made only while the block
// is idle.
// Depends on oaht_pkg, oaht_mod and oaht_store.
module open_addressing_hash_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [oaht_pkg::FUNC_W-1:0]     func,
    input  logic [oaht_pkg::KEY_W-1:0]      key,
    output logic                            done,
    output logic [oaht_pkg::STATUS_W-1:0]   status,
    output logic [oaht_pkg::SLOT_OUT_W-1:0] slot,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oaht_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] S_IDLE  = 2'd0;
    localparam logic [STATE_W-1:0] S_MOD   = 2'd1;
    localparam logic [STATE_W-1:0] S_READ  = 2'd2;
    localparam logic [STATE_W-1:0] S_CHECK = 2'd3;

    logic [STATE_W-1:0]              state_reg, state_next;
    logic [oaht_pkg::CFG_SIZE_W-1:0] table_size_reg, table_size_next;
    logic                            probe_mode_reg, probe_mode_next;
    logic [oaht_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [oaht_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [oaht_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic                            mode_reg, mode_next;
    logic [oaht_pkg::SIZE_W-1:0]     i_reg, i_next;
    logic [oaht_pkg::SLOT_W-1:0]     p_reg, p_next;
    logic [oaht_pkg::SLOT_W-1:0]     d_reg, d_next;
    logic                            done_reg, done_next;
    logic [oaht_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [oaht_pkg::SLOT_OUT_W-1:0] slot_reg, slot_next;

    logic [oaht_pkg::SIZE_W-1:0]     live_size;
    logic                            accept;
    logic                            mod_start, mod_busy, mod_done;
    logic [oaht_pkg::SIZE_W-1:0]     mod_rem;
    oaht_pkg::st_req_t               st_req;
    logic [oaht_pkg::TAG_W-1:0]      rd_tag;
    logic [oaht_pkg::KEY_W-1:0]      rd_key;
    logic [oaht_pkg::SIZE_W:0]       p_sum, d_sum;
    logic [oaht_pkg::SLOT_W-1:0]     p_step, d_step;
    logic                            last_probe;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // A size of zero behaves as one; sizes beyond the memory are clamped.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            live_size = oaht_pkg::SIZE_W'(1);
        end
        else if (32'(table_size_reg) > 32'(oaht_pkg::TABLE_DEPTH))
        begin
            live_size = oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH);
        end
        else
        begin
            live_size = oaht_pkg::SIZE_W'(table_size_reg);
        end
    end

    always_comb
    begin
        table_size_next = table_size_reg;
        probe_mode_next = probe_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                oaht_pkg::REG_TABLE_SIZE: table_size_next = oaht_pkg::CFG_SIZE_W'(cfg_data);
                oaht_pkg::REG_PROBE_MODE: probe_mode_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Modular step along the probe path. With p and d below the size, one
    // subtraction brings p + d back into range. In quadratic mode d holds
    // (2i + 1) mod size, so p walks home + i*i.
    always_comb
    begin
        p_sum  = (oaht_pkg::SIZE_W+1)'(p_reg) + (oaht_pkg::SIZE_W+1)'(d_reg);
        p_step = (p_sum >= {1'b0, size_reg}) ? oaht_pkg::SLOT_W'(p_sum - {1'b0, size_reg})
                                             : oaht_pkg::SLOT_W'(p_sum);
        d_sum  = (oaht_pkg::SIZE_W+1)'(d_reg) + (oaht_pkg::SIZE_W+1)'(2);
        if (size_reg == oaht_pkg::SIZE_W'(1))
        begin
            d_step = '0;
        end
        else
        begin
            d_step = (d_sum >= {1'b0, size_reg}) ? oaht_pkg::SLOT_W'(d_sum - {1'b0, size_reg})
                                                 : oaht_pkg::SLOT_W'(d_sum);
        end
    end

    assign last_probe = (i_reg == size_reg - oaht_pkg::SIZE_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        size_next   = size_reg;
        mode_next   = mode_reg;
        i_next      = i_reg;
        p_next      = p_reg;
        d_next      = d_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        mod_start   = 1'b0;
        st_req      = '0;
        st_req.addr = p_reg;
        st_req.key  = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    key_next  = key;
                    size_next = live_size;
                    mode_next = probe_mode_reg;
                    case (func) inside
                        oaht_pkg::FN_INSERT, oaht_pkg::FN_SEARCH, oaht_pkg::FN_DELETE:
                        begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = oaht_pkg::ST_ABSENT;
                            slot_next   = '0;
                        end
                    endcase
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    p_next     = oaht_pkg::SLOT_W'(mod_rem);
                    i_next     = '0;
                    d_next     = (size_reg == oaht_pkg::SIZE_W'(1)) ? '0
                                                                    : oaht_pkg::SLOT_W'(1);
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                st_req.re  = 1'b1;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (func_reg == oaht_pkg::FN_INSERT)
                begin
                    if (rd_tag != oaht_pkg::TAG_USED)
                    begin
                        st_req.we   = 1'b1;
                        st_req.tag  = oaht_pkg::TAG_USED;
                        done_next   = 1'b1;
                        status_next = oaht_pkg::ST_OK;
                        slot_next   = oaht_pkg::SLOT_OUT_W'(p_reg);
                        state_next  = S_IDLE;
                    end
                    else if (last_probe)
                    begin
                        done_next   = 1'b1;
                        status_next = oaht_pkg::ST_FULL;
                        slot_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + oaht_pkg::SIZE_W'(1);
                        p_next     = p_step;
                        d_next     = mode_reg ? d_step : d_reg;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    if (rd_tag == oaht_pkg::TAG_EMPTY)
                    begin
                        done_next   = 1'b1;
                        status_next = oaht_pkg::ST_ABSENT;
                        slot_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else if (rd_tag == oaht_pkg::TAG_USED && rd_key == key_reg)
                    begin
                        if (func_reg == oaht_pkg::FN_DELETE)
                        begin
                            st_req.we  = 1'b1;
                            st_req.tag = oaht_pkg::TAG_GONE;
                        end
                        done_next   = 1'b1;
                        status_next = oaht_pkg::ST_OK;
                        slot_next   = oaht_pkg::SLOT_OUT_W'(p_reg);
                        state_next  = S_IDLE;
                    end
                    else if (last_probe)
                    begin
                        done_next   = 1'b1;
                        status_next = oaht_pkg::ST_ABSENT;
                        slot_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + oaht_pkg::SIZE_W'(1);
                        p_next     = p_step;
                        d_next     = mode_reg ? d_step : d_reg;
                        state_next = S_READ;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            table_size_reg <= oaht_pkg::CFG_SIZE_W'(64);
            probe_mode_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            table_size_reg <= table_size_next;
            probe_mode_reg <= probe_mode_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        size_reg   <= size_next;
        mode_reg   <= mode_next;
        i_reg      <= i_next;
        p_reg      <= p_next;
        d_reg      <= d_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    oaht_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (key),
        .size  (live_size),
        .busy  (mod_busy),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    oaht_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (st_req),
        .rd_tag (rd_tag),
        .rd_key (rd_key)
    );

    assign done   = done_reg;
    assign status = status_reg;
    assign slot   = slot_reg;

    // The remainder unit only runs while the sequencer waits for it.
    a_mod_in_mod_state : assert property (@(posedge clk) disable iff (!rst_n)
        mod_busy |-> state_reg == S_MOD)
        else $error("remainder unit busy outside of the hash state");

    // The store is written only when a probed slot has been checked.
    a_write_in_check : assert property (@(posedge clk) disable iff (!rst_n)
        st_req.we |-> state_reg == S_CHECK)
        else $error("slot store written outside of the check state");

    // A probe never runs past the live size.
    a_probe_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_CHECK) |->
            (i_reg < size_reg && oaht_pkg::SIZE_W'(p_reg) < size_reg))
        else $error("probe index or slot beyond the live table size");

    // A failed operation reports slot zero.
    a_fail_slot_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != oaht_pkg::ST_OK) |-> slot == '0)
        else $error("nonzero slot on a failed operation");

    // Each accepted operation ends in one result beat as the block becomes free again.
    a_done_ends_op : assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) != S_IDLE && state_reg == S_IDLE) |-> done)
        else $error("operation finished without a result beat");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the open-addressing hash table: directed and random
// insert, search and delete traffic over several table sizes and probe modes.
// Depends on oaht_pkg and open_addressing_hash_table.
`timescale 1ns / 100ps

module testbench;

    localparam logic [oaht_pkg::FUNC_W-1:0] FN_UNDEF = 2'd3;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_OPS     = 1125;
    localparam int POOL_DEPTH     = 48;

    typedef struct packed {
        logic [oaht_pkg::STATUS_W-1:0]   status;
        logic [oaht_pkg::SLOT_OUT_W-1:0] slot;
    } table_answer_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [oaht_pkg::FUNC_W-1:0]     func = '0;
    logic [oaht_pkg::KEY_W-1:0]      key = '0;
    logic                            done;
    logic [oaht_pkg::STATUS_W-1:0]   status;
    logic [oaht_pkg::SLOT_OUT_W-1:0] slot;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [oaht_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the table and its registers.
    logic [oaht_pkg::TAG_W-1:0]      slot_tags [oaht_pkg::TABLE_DEPTH];
    logic [oaht_pkg::KEY_W-1:0]      slot_keys [oaht_pkg::TABLE_DEPTH];
    logic [oaht_pkg::CFG_SIZE_W-1:0] size_reg;
    logic                            quad_mode;

    table_answer_t answers_due[$];
    table_answer_t want;
    logic [oaht_pkg::KEY_W-1:0] key_pool[$];

    int cycle_count  = 0;
    int ops_sent     = 0;
    int cfg_writes   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int found_seen   = 0;
    int full_seen    = 0;
    int absent_seen  = 0;

    open_addressing_hash_table uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .key       (key),
        .done      (done),
        .status    (status),
        .slot      (slot),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned live_slots();
        if (size_reg == 0)
            return 1;
        if (size_reg > oaht_pkg::TABLE_DEPTH)
            return oaht_pkg::TABLE_DEPTH;
        return 32'(size_reg);
    endfunction

    // Walks the probe path of one operation and updates the shadow table.
    function automatic table_answer_t apply_table_op(input logic [oaht_pkg::FUNC_W-1:0] op,
                                                     input logic [oaht_pkg::KEY_W-1:0] k);
        table_answer_t ans;
        int unsigned   n;
        int unsigned   home;
        int unsigned   pos;
        int unsigned   i;
        bit            stop;
        n = live_slots();
        home = 32'(k) % n;
        ans.status = oaht_pkg::ST_ABSENT;
        ans.slot = '0;
        stop = 1'b0;
        if (op == oaht_pkg::FN_INSERT)
        begin
            ans.status = oaht_pkg::ST_FULL;
            for (i = 0; i < n && !stop; i++)
            begin
                pos = (home + (quad_mode ? (i * i) % n : i)) % n;
                if (slot_tags[pos] != oaht_pkg::TAG_USED)
                begin
                    slot_tags[pos] = oaht_pkg::TAG_USED;
                    slot_keys[pos] = k;
                    ans.status = oaht_pkg::ST_OK;
                    ans.slot = pos[oaht_pkg::SLOT_OUT_W-1:0];
                    stop = 1'b1;
                end
            end
        end
        else if (op == oaht_pkg::FN_SEARCH || op == oaht_pkg::FN_DELETE)
        begin
            for (i = 0; i < n && !stop; i++)
            begin
                pos = (home + (quad_mode ? (i * i) % n : i)) % n;
                if (slot_tags[pos] == oaht_pkg::TAG_EMPTY)
                    stop = 1'b1;
                else if (slot_tags[pos] == oaht_pkg::TAG_USED && slot_keys[pos] == k)
                begin
                    if (op == oaht_pkg::FN_DELETE)
                        slot_tags[pos] = oaht_pkg::TAG_GONE;
                    ans.status = oaht_pkg::ST_OK;
                    ans.slot = pos[oaht_pkg::SLOT_OUT_W-1:0];
                    stop = 1'b1;
                end
            end
        end
        return ans;
    endfunction

    task automatic issue_op(input logic [oaht_pkg::FUNC_W-1:0] op,
                            input logic [oaht_pkg::KEY_W-1:0] k);
        start <= 1'b1;
        func <= op;
        key <= k;
        do
            @(posedge clk);
        while (busy);
        answers_due.insert(answers_due.size(), apply_table_op(op, k));
        ops_sent++;
    endtask

    // Random sender gap; a zero gap keeps start high for the next beat.
    task automatic pause_sender();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 55)
            len = 0;
        else if (r < 90)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(8, 40);
        if (len > 0)
        begin
            start <= 1'b0;
            func <= oaht_pkg::FUNC_W'($urandom());
            key <= oaht_pkg::KEY_W'($urandom());
            repeat (len) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [oaht_pkg::CFG_IDX_W-1:0] idx,
                             input logic [oaht_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == oaht_pkg::REG_TABLE_SIZE)
            size_reg = data;
        else
            quad_mode = data[0];
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing pending: status %0d slot %0d",
                             status, slot);
            end
            else
            begin
                want = answers_due.pop_front();
                results_seen++;
                if (status !== want.status || slot !== want.slot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected status %0d slot %0d, got %0d %0d",
                                 results_seen, want.status, want.slot, status, slot);
                end
                if (want.status == oaht_pkg::ST_OK)
                    found_seen++;
                else if (want.status == oaht_pkg::ST_FULL)
                    full_seen++;
                else
                    absent_seen++;
            end
        end
    end

    // Collisions at size 64, tombstones, duplicates, wraparound and an undefined code.
    task automatic test_linear_basics();
        issue_op(oaht_pkg::FN_INSERT, 31'd0);
        issue_op(oaht_pkg::FN_INSERT, 31'h7FFFFFFF);
        issue_op(oaht_pkg::FN_INSERT, 31'd64);
        issue_op(oaht_pkg::FN_INSERT, 31'd128);
        issue_op(oaht_pkg::FN_SEARCH, 31'd128);
        issue_op(oaht_pkg::FN_DELETE, 31'd64);
        issue_op(oaht_pkg::FN_SEARCH, 31'd128);
        issue_op(oaht_pkg::FN_SEARCH, 31'd64);
        issue_op(oaht_pkg::FN_INSERT, 31'd192);
        issue_op(oaht_pkg::FN_INSERT, 31'd0);
        issue_op(oaht_pkg::FN_DELETE, 31'd0);
        issue_op(oaht_pkg::FN_SEARCH, 31'd0);
        issue_op(FN_UNDEF, 31'd5);
        issue_op(oaht_pkg::FN_SEARCH, 31'h55555555);
        issue_op(oaht_pkg::FN_INSERT, 31'h7FFFFFBF);
        drain_results();
    endtask

    // Size one, zero and oversize settings, a quadratic path that misses slots,
    // and a shrink that hides slots until the size grows back.
    task automatic test_size_edges();
        write_reg(oaht_pkg::REG_TABLE_SIZE, 7'd1);
        issue_op(oaht_pkg::FN_INSERT, 31'd7);
        issue_op(oaht_pkg::FN_DELETE, 31'h7FFFFFBF);
        issue_op(oaht_pkg::FN_INSERT, 31'd7);
        drain_results();
        write_reg(oaht_pkg::REG_TABLE_SIZE, 7'd0);
        issue_op(oaht_pkg::FN_SEARCH, 31'd7);
        drain_results();
        write_reg(oaht_pkg::REG_TABLE_SIZE, 7'd127);
        issue_op(oaht_pkg::FN_SEARCH, 31'd192);
        drain_results();
        write_reg(oaht_pkg::REG_TABLE_SIZE, 7'd4);
        write_reg(oaht_pkg::REG_PROBE_MODE, 7'h7F);
        issue_op(oaht_pkg::FN_INSERT, 31'd8);
        issue_op(oaht_pkg::FN_DELETE, 31'd128);
        drain_results();
        write_reg(oaht_pkg::REG_TABLE_SIZE, 7'd64);
        issue_op(oaht_pkg::FN_SEARCH, 31'd128);
        drain_results();
        write_reg(oaht_pkg::REG_PROBE_MODE, 7'h7E);
    endtask

    function automatic logic [oaht_pkg::CFG_SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 7'd0;
        if (r < 16)
            return oaht_pkg::CFG_SIZE_W'($urandom_range(65, 127));
        if (r < 28)
            return 7'd64;
        if (r < 36)
            return 7'd1;
        if (r < 70)
            return oaht_pkg::CFG_SIZE_W'($urandom_range(2, 16));
        return oaht_pkg::CFG_SIZE_W'($urandom_range(17, 64));
    endfunction

    function automatic logic [oaht_pkg::KEY_W-1:0] next_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 60)
            return oaht_pkg::KEY_W'(live_slots() * $urandom_range(0, 40)
                                    + $urandom_range(0, 3));
        if (r < 75)
            return oaht_pkg::KEY_W'(32'h7FFFFFFF - $urandom_range(0, 300));
        return oaht_pkg::KEY_W'($urandom());
    endfunction

    task automatic test_random_traffic();
        int target;
        int burst;
        int r;
        logic [oaht_pkg::FUNC_W-1:0] op;
        logic [oaht_pkg::KEY_W-1:0]  k;
        target = ops_sent + RANDOM_OPS;
        while (ops_sent < target)
        begin
            drain_results();
            if ($urandom_range(0, 4) != 0)
                write_reg(oaht_pkg::REG_TABLE_SIZE, pick_size());
            if ($urandom_range(0, 4) != 0)
                write_reg(oaht_pkg::REG_PROBE_MODE, oaht_pkg::CFG_DATA_W'($urandom()));
            burst = $urandom_range(60, 110);
            if (burst > target - ops_sent)
                burst = target - ops_sent;
            repeat (burst)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    op = oaht_pkg::FN_INSERT;
                else if (r < 70)
                    op = oaht_pkg::FN_SEARCH;
                else if (r < 95)
                    op = oaht_pkg::FN_DELETE;
                else
                    op = FN_UNDEF;
                k = next_key();
                if (op == oaht_pkg::FN_INSERT)
                begin
                    key_pool.insert(key_pool.size(), k);
                    if (key_pool.size() > POOL_DEPTH)
                        void'(key_pool.pop_front());
                end
                issue_op(op, k);
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                else
                    pause_sender();
            end
        end
        drain_results();
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results pending",
                 cycle_count, answers_due.size());
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        for (int j = 0; j < oaht_pkg::TABLE_DEPTH; j++)
        begin
            slot_tags[j] = oaht_pkg::TAG_EMPTY;
            slot_keys[j] = '0;
        end
        size_reg = 7'd64;
        quad_mode = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_linear_basics();
        test_size_edges();
        test_random_traffic();

        repeat (150) @(posedge clk);
        if (answers_due.size() != 0)
        begin
            mismatches++;
            $display("%0d results never arrived", answers_due.size());
        end
        $display("covered %0d operations and %0d register writes, %0d results checked",
                 ops_sent, cfg_writes, results_seen);
        $display("outcomes: %0d done or found, %0d table full, %0d absent; %0d mismatches",
                 found_seen, full_seen, absent_seen, mismatches);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/oaht_pkg.sv
rtl/core/oaht_mod.sv
rtl/core/oaht_store.sv
rtl/core/open_addressing_hash_table.sv
verif/testbench.sv
